// ===== rtl/gdfs_pkg.sv =====
// Package for the adjacency-matrix graph engine: sizes, codes, payload and
// control structs, sequencer state type. Depends on nothing.
package gdfs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = IDX_W + 1;
   localparam int LABEL_W      = 8;
   localparam int VINDEX_W     = 4;
   localparam int EDGE_W       = 16;

   localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

   typedef enum logic [1:0] {
      OP_ADD_VERTEX = 2'd0,
      OP_ADD_EDGE   = 2'd1,
      OP_WALK       = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   typedef struct packed {
      op_type               op;
      logic [LABEL_W-1:0]   label_a;
      logic [LABEL_W-1:0]   label_b;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [LABEL_W-1:0]   vertex_label;
      logic [VINDEX_W-1:0]  vertex_index;
      logic [EDGE_W-1:0]    edge_count;
      logic                 last;
   } rsp_type;

   typedef enum logic {
      SCAN_LABEL     = 1'b0,
      SCAN_NEIGHBOUR = 1'b1
   } scan_mode_type;

   typedef struct packed {
      logic                 en;
      scan_mode_type        mode;
      logic [LABEL_W-1:0]   key;
      logic [CNT_W-1:0]     limit;
   } scan_ctrl_type;

   typedef struct packed {
      logic                 done;
      logic                 found;
      logic [IDX_W-1:0]     idx;
   } scan_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDV,
      ST_FIND_A,
      ST_FIND_B,
      ST_SET_AB,
      ST_SET_BA,
      ST_FIND_S,
      ST_NSCAN,
      ST_PUSH,
      ST_REPLY
   } state_type;

endpackage

// ===== rtl/gdfs_scan.sv =====
// Shared scan unit: steps one table index a cycle and compares a label or
// tests a neighbour bit. Depends on gdfs_pkg.
module gdfs_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  gdfs_pkg::scan_ctrl_type       ctrl,
   input  logic [gdfs_pkg::LABEL_W-1:0]  label_rd,
   input  logic [gdfs_pkg::MAX_VERTICES-1:0] row,
   input  logic [gdfs_pkg::MAX_VERTICES-1:0] visited,
   output gdfs_pkg::scan_stat_type       stat
);

   logic [gdfs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       at_end;
   logic                       hit;

   always_comb begin
      at_end = {1'b0, idx_ff} >= ctrl.limit;
      case (ctrl.mode)
         gdfs_pkg::SCAN_LABEL:     hit = (label_rd == ctrl.key);
         gdfs_pkg::SCAN_NEIGHBOUR: hit = row[idx_ff] & ~visited[idx_ff];
         default:                  hit = 1'b0;
      endcase
      stat.idx   = idx_ff;
      stat.found = ctrl.en & ~at_end & hit;
      stat.done  = ctrl.en & (at_end | hit |
                   (idx_ff == gdfs_pkg::IDX_W'(gdfs_pkg::MAX_VERTICES - 1)));
      // restart from index zero once a scan finishes or is idle
      idx_in = (ctrl.en && !stat.done) ? idx_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== rtl/adjacency_matrix_graph_dfs_top.sv =====
// Top level of the undirected graph engine with depth-first traversal.
// Depends on gdfs_pkg and gdfs_scan.
//
// One request transaction is taken at a time; req_stall stays high until its
// last response transaction has been placed in the output register. Add
// vertex writes the label table unless it is full, then replies. Add edge
// scans the label table once per end, one entry a cycle, then sets both
// adjacency bits. A traversal looks up the start label the same way, then
// for every step rescans the current stack top's adjacency row from index
// zero, one bit a cycle; each vertex pushed passes a push state that waits
// for room in the output register, and every pop restarts the scan. Every
// lookup and scan uses the single shared scan unit. The final response of
// every request carries last high; the output register lets the next
// request be taken while that response waits.
module adjacency_matrix_graph_dfs_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gdfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gdfs_pkg::rsp_type rsp_data
);

   localparam int MV = gdfs_pkg::MAX_VERTICES;
   localparam int IW = gdfs_pkg::IDX_W;
   localparam int CW = gdfs_pkg::CNT_W;
   localparam int LW = gdfs_pkg::LABEL_W;

   // sequencer and control state
   gdfs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [gdfs_pkg::EDGE_W-1:0] edges_ff, edges_in;
   logic [MV-1:0]       visited_ff, visited_in;
   logic [CW-1:0]       depth_ff, depth_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [MV-1:0]       adj_ff [MV];
   logic [MV-1:0]       adj_in [MV];
   logic                rsp_valid_ff, rsp_valid_in;

   // payload held for the transaction in flight
   logic [LW-1:0]       la_ff, la_in;
   logic [LW-1:0]       lb_ff, lb_in;
   logic [IW-1:0]       ia_ff, ia_in;
   logic [IW-1:0]       ib_ff, ib_in;
   logic [IW-1:0]       w_ff, w_in;
   logic [LW-1:0]       wl_ff, wl_in;
   gdfs_pkg::rsp_type   hold_ff, hold_in;
   gdfs_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // label table and walk stack
   logic [LW-1:0]       labels_ff [MV];
   logic [IW-1:0]       stack_ff [MV];
   logic                lbl_we;
   logic [IW-1:0]       lbl_addr;
   logic                stk_we;
   logic [IW-1:0]       stk_addr;
   logic [IW-1:0]       stk_wdata;

   gdfs_pkg::scan_ctrl_type scan_ctrl;
   gdfs_pkg::scan_stat_type scan_stat;
   logic [LW-1:0]       label_rd;
   logic [CW-1:0]       depth_m1;
   logic [IW-1:0]       top_idx;
   logic                rsp_free;
   logic                push_ok;
   logic                rsp_load;
   logic                rsp_last;

   assign req_stall = (state_ff != gdfs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // output register can take a result when empty or being emptied
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign depth_m1 = depth_ff - 1'b1;
   // vertex index held at the top of the walk stack
   assign top_idx  = stack_ff[depth_m1[IW-1:0]];
   assign label_rd = labels_ff[scan_stat.idx];
   assign push_ok  = scan_stat.found && (depth_ff < CW'(MV)) && (n_ff < CW'(MV));

   always_comb begin
      scan_ctrl.en    = (state_ff == gdfs_pkg::ST_FIND_A) ||
                        (state_ff == gdfs_pkg::ST_FIND_B) ||
                        (state_ff == gdfs_pkg::ST_FIND_S) ||
                        (state_ff == gdfs_pkg::ST_NSCAN);
      scan_ctrl.mode  = (state_ff == gdfs_pkg::ST_NSCAN) ?
                        gdfs_pkg::SCAN_NEIGHBOUR : gdfs_pkg::SCAN_LABEL;
      scan_ctrl.key   = (state_ff == gdfs_pkg::ST_FIND_B) ? lb_ff : la_ff;
      scan_ctrl.limit = count_ff;
   end

   gdfs_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .label_rd (label_rd),
      .row      (adj_ff[top_idx]),
      .visited  (visited_ff),
      .stat     (scan_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdfs_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.op)
                  gdfs_pkg::OP_ADD_VERTEX: state_in = gdfs_pkg::ST_ADDV;
                  gdfs_pkg::OP_ADD_EDGE:   state_in = gdfs_pkg::ST_FIND_A;
                  gdfs_pkg::OP_WALK:       state_in = gdfs_pkg::ST_FIND_S;
                  gdfs_pkg::OP_NONE:       state_in = gdfs_pkg::ST_IDLE;
                  default:                 state_in = gdfs_pkg::ST_IDLE;
               endcase
            end
         end
         gdfs_pkg::ST_ADDV: state_in = gdfs_pkg::ST_REPLY;
         gdfs_pkg::ST_FIND_A: begin
            if (scan_stat.done) begin
               state_in = scan_stat.found ? gdfs_pkg::ST_FIND_B : gdfs_pkg::ST_REPLY;
            end
         end
         gdfs_pkg::ST_FIND_B: begin
            if (scan_stat.done) begin
               state_in = scan_stat.found ? gdfs_pkg::ST_SET_AB : gdfs_pkg::ST_REPLY;
            end
         end
         gdfs_pkg::ST_SET_AB: state_in = gdfs_pkg::ST_SET_BA;
         gdfs_pkg::ST_SET_BA: state_in = gdfs_pkg::ST_REPLY;
         gdfs_pkg::ST_FIND_S: begin
            if (scan_stat.done) begin
               state_in = scan_stat.found ? gdfs_pkg::ST_NSCAN : gdfs_pkg::ST_REPLY;
            end
         end
         gdfs_pkg::ST_NSCAN: begin
            if (scan_stat.done) begin
               if (push_ok) begin
                  state_in = gdfs_pkg::ST_PUSH;
               end else if (depth_ff == CW'(1)) begin
                  state_in = gdfs_pkg::ST_REPLY;
               end
            end
         end
         gdfs_pkg::ST_PUSH: begin
            if (rsp_free) state_in = gdfs_pkg::ST_NSCAN;
         end
         gdfs_pkg::ST_REPLY: begin
            if (rsp_free) state_in = gdfs_pkg::ST_IDLE;
         end
         default: state_in = gdfs_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in   = count_ff;
      edges_in   = edges_ff;
      visited_in = visited_ff;
      depth_in   = depth_ff;
      n_in       = n_ff;
      adj_in     = adj_ff;
      la_in      = la_ff;
      lb_in      = lb_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      w_in       = w_ff;
      wl_in      = wl_ff;
      hold_in    = hold_ff;
      lbl_we     = 1'b0;
      lbl_addr   = count_ff[IW-1:0];
      stk_we     = 1'b0;
      stk_addr   = depth_ff[IW-1:0];
      stk_wdata  = w_ff;
      rsp_load   = 1'b0;
      rsp_last   = 1'b0;

      unique case (state_ff)
         gdfs_pkg::ST_IDLE: begin
            if (req_valid) begin
               la_in = req_data.label_a;
               lb_in = req_data.label_b;
               // fresh traversal: drop marks and stack
               if (req_data.op == gdfs_pkg::OP_WALK) begin
                  visited_in = '0;
                  depth_in   = '0;
               end
            end
         end
         gdfs_pkg::ST_ADDV: begin
            hold_in.vertex_label = '0;
            if (count_ff >= CW'(MV)) begin
               hold_in.status       = gdfs_pkg::STATUS_FULL;
               hold_in.vertex_index = '0;
            end else begin
               lbl_we               = 1'b1;
               hold_in.status       = gdfs_pkg::STATUS_OK;
               hold_in.vertex_index = gdfs_pkg::VINDEX_W'(count_ff[IW-1:0]);
               count_in             = count_ff + 1'b1;
            end
         end
         gdfs_pkg::ST_FIND_A, gdfs_pkg::ST_FIND_B: begin
            if (scan_stat.done) begin
               if (scan_stat.found) begin
                  if (state_ff == gdfs_pkg::ST_FIND_A) ia_in = scan_stat.idx;
                  else                                 ib_in = scan_stat.idx;
               end else begin
                  hold_in.status       = gdfs_pkg::STATUS_MISSING;
                  hold_in.vertex_label = '0;
                  hold_in.vertex_index = '0;
               end
            end
         end
         gdfs_pkg::ST_SET_AB: begin
            adj_in[ia_ff][ib_ff] = 1'b1;
         end
         gdfs_pkg::ST_SET_BA: begin
            adj_in[ib_ff][ia_ff] = 1'b1;
            if (edges_ff != gdfs_pkg::EDGE_MAX) edges_in = edges_ff + 1'b1;
            hold_in.status       = gdfs_pkg::STATUS_OK;
            hold_in.vertex_label = '0;
            hold_in.vertex_index = '0;
         end
         gdfs_pkg::ST_FIND_S: begin
            if (scan_stat.done) begin
               if (scan_stat.found) begin
                  visited_in[scan_stat.idx] = 1'b1;
                  stk_we               = 1'b1;
                  stk_addr             = '0;
                  stk_wdata            = scan_stat.idx;
                  depth_in             = CW'(1);
                  n_in                 = CW'(1);
                  hold_in.status       = gdfs_pkg::STATUS_OK;
                  hold_in.vertex_label = label_rd;
                  hold_in.vertex_index = gdfs_pkg::VINDEX_W'(scan_stat.idx);
               end else begin
                  hold_in.status       = gdfs_pkg::STATUS_MISSING;
                  hold_in.vertex_label = '0;
                  hold_in.vertex_index = '0;
               end
            end
         end
         gdfs_pkg::ST_NSCAN: begin
            if (scan_stat.done) begin
               if (push_ok) begin
                  w_in  = scan_stat.idx;
                  wl_in = label_rd;
               end else begin
                  depth_in = depth_m1;
               end
            end
         end
         gdfs_pkg::ST_PUSH: begin
            // release the held vertex, then hold the new one until the walk
            // shows whether it is the final one
            if (rsp_free) begin
               rsp_load             = 1'b1;
               visited_in[w_ff]     = 1'b1;
               stk_we               = 1'b1;
               depth_in             = depth_ff + 1'b1;
               n_in                 = n_ff + 1'b1;
               hold_in.status       = gdfs_pkg::STATUS_OK;
               hold_in.vertex_label = wl_ff;
               hold_in.vertex_index = gdfs_pkg::VINDEX_W'(w_ff);
            end
         end
         gdfs_pkg::ST_REPLY: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_last = 1'b1;
            end
         end
         default: begin
         end
      endcase

      hold_in.edge_count = edges_ff;
      hold_in.last       = 1'b0;

      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in            = hold_ff;
         rsp_data_in.edge_count = edges_ff;
         rsp_data_in.last       = rsp_last;
      end
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdfs_pkg::ST_IDLE;
         count_ff     <= '0;
         edges_ff     <= '0;
         visited_ff   <= '0;
         depth_ff     <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MV; r++) begin
            adj_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         edges_ff     <= edges_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         adj_ff       <= adj_in;
      end
   end

   always_ff @(posedge clock) begin
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      w_ff        <= w_in;
      wl_ff       <= wl_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
      if (lbl_we) labels_ff[lbl_addr] <= la_ff;
      if (stk_we) stack_ff[stk_addr] <= stk_wdata;
   end

   // stack never grows beyond the table
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CW'(MV))
      else $error("walk stack depth beyond table size");

   // vertex table fill never overruns
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MV))
      else $error("vertex count beyond table size");

   // the vertex whose row is scanned has always been marked visited
   a_top_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfs_pkg::ST_NSCAN) |-> (depth_ff != '0) && visited_ff[top_idx])
      else $error("neighbour scan on empty stack or unvisited top");

   // a completed edge always leaves a non-zero count
   a_edge_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfs_pkg::ST_SET_BA) |=> (edges_ff != '0))
      else $error("edge added without counting");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the adjacency-matrix graph engine with depth-first walk.
// Depends on gdfs_pkg and adjacency_matrix_graph_dfs_top; a local graph mirror
// predicts every response transaction.
module tb_top;

   // Self edges on one vertex, sent back to back with no idling on either
   // side.
   localparam int BURST_EDGES    = 20;
   localparam int RANDOM_ITEMS   = 250;
   localparam int IDLE_PERCENT   = 18;
   localparam int HOLD_AT        = BURST_EDGES + 80;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 600;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      gdfs_pkg::req_type req;
      bit                calm;
   } queued_req_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   gdfs_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   gdfs_pkg::rsp_type rsp_data;

   queued_req_type    pending_reqs[$];
   gdfs_pkg::rsp_type due_replies[$];

   // Mirror of the graph state inside the block
   logic [gdfs_pkg::LABEL_W-1:0]      mirror_labels[gdfs_pkg::MAX_VERTICES];
   int                                mirror_count = 0;
   logic [gdfs_pkg::MAX_VERTICES-1:0] mirror_rows[gdfs_pkg::MAX_VERTICES];
   logic [gdfs_pkg::EDGE_W-1:0]       mirror_edges = '0;

   bit calm_zone    = 1'b0;
   bit hold_done    = 1'b0;
   int hold_left    = 0;
   int quiet_cycles = 0;
   int mismatches   = 0;
   int total_items  = 0;
   int accepted     = 0;
   int replies_seen = 0;
   int n_add_vertex = 0;
   int n_add_edge   = 0;
   int n_walk       = 0;
   int n_ignored    = 0;
   int n_walk_steps = 0;

   adjacency_matrix_graph_dfs_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Graph mirror: lowest matching index wins, as in the block
   // ---------------------------------------------------------------
   function automatic int find_vertex(input logic [gdfs_pkg::LABEL_W-1:0] lbl);
      int hit;
      hit = -1;
      for (int k = mirror_count - 1; k >= 0; k--)
         if (mirror_labels[k] == lbl)
            hit = k;
      return hit;
   endfunction

   function automatic gdfs_pkg::rsp_type make_reply(input gdfs_pkg::status_type st,
                                                    input logic [gdfs_pkg::LABEL_W-1:0] lbl,
                                                    input int idx, input logic fin);
      gdfs_pkg::rsp_type r;
      r.status       = st;
      r.vertex_label = lbl;
      r.vertex_index = gdfs_pkg::VINDEX_W'(idx);
      r.edge_count   = mirror_edges;
      r.last         = fin;
      return r;
   endfunction

   // Work out the responses of one accepted request and update the mirror
   task automatic compute_graph_replies(input gdfs_pkg::req_type rq);
      int                                ia, ib, depth, n, top, nxt;
      int                                trail[gdfs_pkg::MAX_VERTICES];
      logic [gdfs_pkg::MAX_VERTICES-1:0] seen;
      gdfs_pkg::rsp_type                 walk_out[gdfs_pkg::MAX_VERTICES];
      case (rq.op)
         gdfs_pkg::OP_ADD_VERTEX: begin
            n_add_vertex++;
            if (mirror_count >= gdfs_pkg::MAX_VERTICES) begin
               due_replies.push_back(make_reply(gdfs_pkg::STATUS_FULL, '0, 0, 1'b1));
            end else begin
               mirror_labels[mirror_count] = rq.label_a;
               due_replies.push_back(make_reply(gdfs_pkg::STATUS_OK, '0, mirror_count,
                                                1'b1));
               mirror_count++;
            end
         end
         gdfs_pkg::OP_ADD_EDGE: begin
            n_add_edge++;
            ia = find_vertex(rq.label_a);
            ib = find_vertex(rq.label_b);
            if (ia < 0 || ib < 0) begin
               due_replies.push_back(make_reply(gdfs_pkg::STATUS_MISSING, '0, 0, 1'b1));
            end else begin
               mirror_rows[ia][ib] = 1'b1;
               mirror_rows[ib][ia] = 1'b1;
               if (mirror_edges != gdfs_pkg::EDGE_MAX)
                  mirror_edges++;
               due_replies.push_back(make_reply(gdfs_pkg::STATUS_OK, '0, 0, 1'b1));
            end
         end
         gdfs_pkg::OP_WALK: begin
            n_walk++;
            ia = find_vertex(rq.label_a);
            if (ia < 0) begin
               due_replies.push_back(make_reply(gdfs_pkg::STATUS_MISSING, '0, 0, 1'b1));
            end else begin
               // Visited marks start clear on every walk
               seen        = '0;
               seen[ia]    = 1'b1;
               trail[0]    = ia;
               depth       = 1;
               walk_out[0] = make_reply(gdfs_pkg::STATUS_OK, mirror_labels[ia], ia, 1'b0);
               n           = 1;
               while (depth > 0) begin
                  top = trail[depth-1];
                  nxt = -1;
                  for (int w = 0; w < mirror_count; w++)
                     if (nxt < 0 && mirror_rows[top][w] && !seen[w])
                        nxt = w;
                  if (nxt >= 0 && depth < gdfs_pkg::MAX_VERTICES &&
                      n < gdfs_pkg::MAX_VERTICES) begin
                     seen[nxt]    = 1'b1;
                     trail[depth] = nxt;
                     depth++;
                     walk_out[n]  = make_reply(gdfs_pkg::STATUS_OK, mirror_labels[nxt], nxt,
                                               1'b0);
                     n++;
                  end else begin
                     depth--;
                  end
               end
               walk_out[n-1].last = 1'b1;
               for (int k = 0; k < n; k++)
                  due_replies.push_back(walk_out[k]);
               n_walk_steps += n;
            end
         end
         default: n_ignored++;
      endcase
   endtask

   // ---------------------------------------------------------------
   // Driver: offer queued requests, idling at random outside the burst
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      queued_req_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            compute_graph_replies(req_data);
            accepted++;
         end
         // Hold a stalled payload; otherwise advance or idle
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 &&
                (pending_reqs[0].calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               head = pending_reqs.pop_front();
               calm_zone <= head.calm;
               req_data  <= head.req;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check each response transaction, stall at random, and
   // hold off once for a long stretch so the block backs up
   // ---------------------------------------------------------------
   always @(posedge clock) begin : observe_proc
      gdfs_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_seen++;
            if (due_replies.size() == 0) begin
               $error("response %h arrived with nothing outstanding", rsp_data);
               mismatches++;
            end else begin
               want = due_replies.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.vertex_label !== want.vertex_label) begin
                  $error("vertex_label: expected %0h, got %0h",
                         want.vertex_label, rsp_data.vertex_label);
                  mismatches++;
               end
               if (rsp_data.vertex_index !== want.vertex_index) begin
                  $error("vertex_index: expected %0d, got %0d",
                         want.vertex_index, rsp_data.vertex_index);
                  mismatches++;
               end
               if (rsp_data.edge_count !== want.edge_count) begin
                  $error("edge_count: expected %0d, got %0d",
                         want.edge_count, rsp_data.edge_count);
                  mismatches++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  mismatches++;
               end
            end
         end
         if (!hold_done && replies_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm_zone && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Watchdog: count cycles in which no transaction moves on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog_proc
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic void queue_req(input gdfs_pkg::op_type op,
                                     input logic [gdfs_pkg::LABEL_W-1:0] la,
                                     input logic [gdfs_pkg::LABEL_W-1:0] lb,
                                     input bit calm = 1'b0);
      queued_req_type q;
      q.req.op      = op;
      q.req.label_a = la;
      q.req.label_b = lb;
      q.calm        = calm;
      pending_reqs.push_back(q);
   endfunction

   initial begin : stimulus_proc
      logic [gdfs_pkg::LABEL_W-1:0] planned[$];
      logic [gdfs_pkg::LABEL_W-1:0] la, lb;
      int                           roll, made;

      for (int k = 0; k < gdfs_pkg::MAX_VERTICES; k++)
         mirror_rows[k] = '0;

      // Empty table: walk and edge both miss; unused op code is dropped
      queue_req(gdfs_pkg::OP_WALK, 8'h00, 8'h00);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'h00, 8'hFF);
      queue_req(gdfs_pkg::OP_NONE, 8'hFF, 8'hFF);
      queue_req(gdfs_pkg::OP_ADD_VERTEX, 8'h00, 8'hFF);
      // Back-to-back stretch of repeated self edges
      for (int k = 0; k < BURST_EDGES; k++)
         queue_req(gdfs_pkg::OP_ADD_EDGE, 8'h00, 8'h00, 1'b1);
      queue_req(gdfs_pkg::OP_WALK, 8'h00, 8'h00);
      queue_req(gdfs_pkg::OP_ADD_VERTEX, 8'hFF, 8'h00);
      queue_req(gdfs_pkg::OP_ADD_VERTEX, 8'hA5, 8'h00);
      queue_req(gdfs_pkg::OP_ADD_VERTEX, 8'h5A, 8'h00);
      // Duplicate label: never reached by a lookup, so left isolated
      queue_req(gdfs_pkg::OP_ADD_VERTEX, 8'hA5, 8'hFF);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'hFF, 8'hA5);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'hA5, 8'h5A);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'h00, 8'hFF);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'hA5, 8'hA5);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'h5A, 8'h77);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'h77, 8'h00);
      queue_req(gdfs_pkg::OP_WALK, 8'hA5, 8'h00);
      queue_req(gdfs_pkg::OP_WALK, 8'h77, 8'hFF);
      queue_req(gdfs_pkg::OP_ADD_EDGE, 8'hA5, 8'h00);
      queue_req(gdfs_pkg::OP_WALK, 8'h5A, 8'h00);
      queue_req(gdfs_pkg::OP_NONE, 8'h00, 8'h00);
      queue_req(gdfs_pkg::OP_WALK, 8'hFF, 8'hFF);
      planned = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hA5};

      // Random part: mostly known labels so lookups hit and walks go deep;
      // the table fills up part way through and later adds report full
      made = 0;
      while (made < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         la   = ($urandom_range(99) < 85) ? planned[$urandom_range(planned.size() - 1)]
                                          : gdfs_pkg::LABEL_W'($urandom_range(255));
         lb   = ($urandom_range(99) < 85) ? planned[$urandom_range(planned.size() - 1)]
                                          : gdfs_pkg::LABEL_W'($urandom_range(255));
         if (roll < 5) begin
            queue_req(gdfs_pkg::OP_NONE, la, lb);
         end else if (roll < 22) begin
            la = gdfs_pkg::LABEL_W'($urandom_range(255));
            if (planned.size() < gdfs_pkg::MAX_VERTICES)
               planned.push_back(la);
            queue_req(gdfs_pkg::OP_ADD_VERTEX, la, lb);
            made++;
         end else if (roll < 62) begin
            queue_req(gdfs_pkg::OP_ADD_EDGE, la, lb);
            made++;
         end else begin
            queue_req(gdfs_pkg::OP_WALK, la, lb);
            made++;
         end
      end
      total_items = pending_reqs.size();

      // Hold reset at first, then release it for good
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (accepted == total_items);
      wait (due_replies.size() == 0);
      // Let any stray response surface before closing
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_replies.size() != 0) begin
         $error("%0d responses never arrived", due_replies.size());
         mismatches++;
      end

      $display("Ran %0d requests: %0d vertex adds, %0d edge adds, %0d walks, %0d ignored.",
               accepted, n_add_vertex, n_add_edge, n_walk, n_ignored);
      $display("Checked %0d responses, %0d from walks; final edge count %0d, %0d vertices.",
               replies_seen, n_walk_steps, mirror_edges, mirror_count);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
